// ===== rtl/x86_word_multiply_divide_macros.svh =====
// Assertion macros for the word multiply/divide unit
`ifndef X86_WORD_MULTIPLY_DIVIDE_MACROS_SVH
`define X86_WORD_MULTIPLY_DIVIDE_MACROS_SVH
// a implies b at the same edge
`define XMD_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// a implies b at the next edge
`define XMD_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// ===== rtl/xwmd_pkg.sv =====
// Package: operation codes and shared types for the word multiply/divide unit
package xwmd_pkg;
   localparam logic [2:0] OP_MUL   = 3'd0;
   localparam logic [2:0] OP_IMUL  = 3'd1;
   localparam logic [2:0] OP_DIV   = 3'd2;
   localparam logic [2:0] OP_IDIV  = 3'd3;
   localparam logic [2:0] OP_IMULT = 3'd4;

   typedef struct packed {
      logic is_mul;
      logic is_umul;
      logic is_trunc;
      logic is_div;
      logic is_sdiv;
      logic neg_q;
      logic neg_r;
      logic zero_div;
      logic div_carry;
   } ctl_type;
endpackage

// ===== rtl/xwmd_if.sv =====
// Valid/ready channel interfaces for requests, responses and the register write
interface xwmd_req_if #(parameter int WORD_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [2:0]           req_type;
   logic [WORD_BITS-1:0] acc_low;
   logic [WORD_BITS-1:0] acc_high;
   logic [WORD_BITS-1:0] src_operand;
   logic [WORD_BITS-1:0] other_operand;
   modport source (output valid, req_type, acc_low, acc_high, src_operand, other_operand,
                   input ready);
   modport sink (input valid, req_type, acc_low, acc_high, src_operand, other_operand,
                 output ready);
endinterface

interface xwmd_rsp_if #(parameter int WORD_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] result_low;
   logic [WORD_BITS-1:0] result_high;
   logic                 carry_write;
   logic                 carry_value;
   logic                 overflow_write;
   logic                 overflow_value;
   logic                 divide_error;
   modport source (output valid, result_low, result_high, carry_write, carry_value,
                   overflow_write, overflow_value, divide_error, input ready);
   modport sink (input valid, result_low, result_high, carry_write, carry_value,
                 overflow_write, overflow_value, divide_error, output ready);
endinterface

interface xwmd_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== rtl/xwmd_div_stage.sv =====
// One registered stage of the restoring divider: STEPS quotient bits
module xwmd_div_stage import xwmd_pkg::*; #(
   parameter int WORD_BITS = 16,
   parameter int STEPS     = 4
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [WORD_BITS:0]     rem_in,
   input  logic [2*WORD_BITS-1:0] dvd_in,
   input  logic [WORD_BITS-1:0]   dsr_in,
   output logic [WORD_BITS:0]     rem_out,
   output logic [2*WORD_BITS-1:0] dvd_out,
   output logic [WORD_BITS-1:0]   dsr_out
);
   logic [WORD_BITS:0]     rem_ff, rem_in_c;
   logic [2*WORD_BITS-1:0] dvd_ff, dvd_in_c;
   logic [WORD_BITS-1:0]   dsr_ff;

   always_comb begin
      logic [WORD_BITS+1:0] t;
      rem_in_c = rem_in;
      dvd_in_c = dvd_in;
      for (int i = 0; i < STEPS; i++) begin
         t = {rem_in_c, dvd_in_c[2*WORD_BITS-1]};
         dvd_in_c = {dvd_in_c[2*WORD_BITS-2:0], 1'b0};
         if (t >= {2'b00, dsr_in}) begin
            t = t - {2'b00, dsr_in};
            dvd_in_c[0] = 1'b1;
         end
         rem_in_c = t[WORD_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in_c;
         dvd_ff <= dvd_in_c;
         dsr_ff <= dsr_in;
      end
   end

   assign rem_out = rem_ff;
   assign dvd_out = dvd_ff;
   assign dsr_out = dsr_ff;
endmodule

// ===== rtl/x86_word_multiply_divide.sv =====
// Top level: pipelined 16-bit x86 MUL/IMUL/DIV/IDIV unit
//  channel | dir | contents
//  req     | in  | req_type, acc_low, acc_high, src_operand, other_operand
//  rsp     | out | result words, CF/OF write and value, divide_error
//  csr     | in  | div_sets_carry
// After the request transfer a result passes the decode register, then divider
// stages of four quotient bits each (two for odd WORD_BITS).
// One item per cycle unless rsp stalls; the product runs beside the divider stages.
// Synchronous reset clears valid bits and div_sets_carry.
// A stall on rsp freezes the whole pipeline; nothing is lost or repeated.
module x86_word_multiply_divide import xwmd_pkg::*; #(
   parameter int WORD_BITS = 16
) (
   input logic    clock,
   input logic    reset,
   xwmd_req_if.sink   req,
   xwmd_rsp_if.source rsp,
   xwmd_csr_if.sink   csr
);
`include "x86_word_multiply_divide_macros.svh"
   localparam int W     = WORD_BITS;
   localparam int STEPS = (W % 2 == 0) ? 4 : 2;
   localparam int NDIV  = (2*W + STEPS - 1) / STEPS;
   localparam int NST   = NDIV + 1;

   logic advance;
   logic div_carry_ff;
   logic [NST-1:0] vld_ff;
   ctl_type        ctl_ff [NST];
   logic [2*W-1:0] prod_ff [NST];

   assign advance   = !vld_ff[NST-1] || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) div_carry_ff <= 1'b0;
      else if (csr.valid) div_carry_ff <= csr.data;
   end

   // stage 0: decode, magnitudes
   ctl_type        ctl_in;
   logic [2*W-1:0] mag_in;
   logic [W-1:0]   dsr_in, ma_in, mb_in;
   logic           nd, ns;
   always_comb begin
      nd = req.acc_high[W-1];
      ns = req.src_operand[W-1];
      ctl_in = '0;
      ctl_in.is_mul   = req.req_type == OP_MUL || req.req_type == OP_IMUL ||
                        req.req_type == OP_IMULT;
      ctl_in.is_umul  = req.req_type == OP_MUL;
      ctl_in.is_trunc = req.req_type == OP_IMULT;
      ctl_in.is_div   = req.req_type == OP_DIV || req.req_type == OP_IDIV;
      ctl_in.is_sdiv  = req.req_type == OP_IDIV;
      ctl_in.zero_div = req.src_operand == '0;
      ctl_in.div_carry = div_carry_ff;
      mag_in = {req.acc_high, req.acc_low};
      dsr_in = req.src_operand;
      if (ctl_in.is_sdiv) begin
         if (nd) mag_in = -{req.acc_high, req.acc_low};
         if (ns) dsr_in = -req.src_operand;
         ctl_in.neg_q = nd ^ ns;
         ctl_in.neg_r = nd;
      end
      ma_in = (req.req_type == OP_IMULT) ? req.other_operand : req.acc_low;
      mb_in = req.src_operand;
   end

   // multiplier operands registered at stage 0, product at stage 1
   logic [W-1:0] ma_ff, mb_ff;
   logic [2*W-1:0] prod_c;
   always_comb begin
      if (ctl_ff[0].is_umul) prod_c = {{W{1'b0}}, ma_ff} * {{W{1'b0}}, mb_ff};
      else prod_c = $signed({{W{ma_ff[W-1]}}, ma_ff}) * $signed({{W{mb_ff[W-1]}}, mb_ff});
   end

   logic [W:0]     rem [NDIV+1];
   logic [2*W-1:0] dvd [NDIV+1];
   logic [W-1:0]   dsr [NDIV+1];
   logic [W:0]     rem0_ff;
   logic [2*W-1:0] dvd0_ff;
   logic [W-1:0]   dsr0_ff;
   assign rem[0] = rem0_ff;
   assign dvd[0] = dvd0_ff;
   assign dsr[0] = dsr0_ff;

   for (genvar g = 0; g < NDIV; g++) begin : g_div
      xwmd_div_stage #(.WORD_BITS(W), .STEPS(STEPS)) u_stage (
         .clock(clock), .advance(advance),
         .rem_in(rem[g]), .dvd_in(dvd[g]), .dsr_in(dsr[g]),
         .rem_out(rem[g+1]), .dvd_out(dvd[g+1]), .dsr_out(dsr[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[NST-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff[0] <= ctl_in;
         ma_ff     <= ma_in;
         mb_ff     <= mb_in;
         rem0_ff   <= '0;
         dvd0_ff   <= mag_in;
         dsr0_ff   <= ctl_in.zero_div ? W'(1) : dsr_in;
         prod_ff[0] <= '0;
         ctl_ff[1] <= ctl_ff[0];
         prod_ff[1] <= prod_c;
         for (int s = 2; s < NST; s++) begin
            ctl_ff[s]  <= ctl_ff[s-1];
            prod_ff[s] <= prod_ff[s-1];
         end
      end
   end

   // output from the last stage
   ctl_type        c;
   logic [2*W-1:0] q_full;
   logic [W-1:0]   q, r, plo, phi;
   logic           qovf, mof;
   always_comb begin
      c      = ctl_ff[NST-1];
      q_full = dvd[NDIV];
      q      = c.neg_q ? -q_full[W-1:0] : q_full[W-1:0];
      r      = c.neg_r ? -rem[NDIV][W-1:0] : rem[NDIV][W-1:0];
      if (c.is_sdiv)
         qovf = q_full[2*W-1:W] != '0 ||
                (c.neg_q ? q_full[W-1:0] > {1'b1, {(W-1){1'b0}}} : q_full[W-1]);
      else
         qovf = q_full[2*W-1:W] != '0;
      plo = prod_ff[NST-1][W-1:0];
      phi = prod_ff[NST-1][2*W-1:W];
      if (c.is_umul) mof = phi != '0;
      else mof = phi != {W{plo[W-1]}};
      rsp.result_low = '0; rsp.result_high = '0;
      rsp.carry_write = 1'b0; rsp.carry_value = 1'b0;
      rsp.overflow_write = 1'b0; rsp.overflow_value = 1'b0;
      rsp.divide_error = 1'b0;
      if (c.is_mul) begin
         rsp.result_low = plo;
         rsp.result_high = c.is_trunc ? '0 : phi;
         rsp.carry_write = 1'b1; rsp.overflow_write = 1'b1;
         rsp.carry_value = mof; rsp.overflow_value = mof;
      end else if (c.is_div) begin
         if (c.zero_div || qovf) rsp.divide_error = 1'b1;
         else begin
            rsp.result_low = q; rsp.result_high = r;
            rsp.carry_write = c.div_carry; rsp.carry_value = c.div_carry;
         end
      end
   end
   assign rsp.valid = vld_ff[NST-1];

   `XMD_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready,
                    rsp.valid && $stable(rsp.result_low))
   `XMD_ASSERT_IMPL(a_err_clean, clock, reset, rsp.valid && rsp.divide_error,
                    rsp.result_low == '0 && !rsp.carry_write && !rsp.overflow_write)
   `XMD_ASSERT_IMPL(a_trunc_high, clock, reset, rsp.valid && c.is_trunc,
                    rsp.result_high == '0)
endmodule

// ===== tb/sv/x86_word_multiply_divide_test.sv =====
// Testbench for the word multiply/divide unit: directed table plus random, self-checking
module x86_word_multiply_divide_test;
   import xwmd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WB = 16;
   localparam int LATENCY = 2*WB/4+3;
   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 800;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] ax, dx, src, oth;
   } mdu_req_type;

   typedef struct packed {
      logic [15:0] lo, hi;
      logic cw, cv, ow, ov, de;
   } mdu_rsp_type;

   typedef struct packed {
      mdu_req_type req;
      logic        known;
      mdu_rsp_type rsp;
   } table_row_type;

   logic clock = 0;
   logic reset = 1;
   always #2 clock = ~clock;

   xwmd_req_if #(WB) req ();
   xwmd_rsp_if #(WB) rsp ();
   xwmd_csr_if csr ();

   x86_word_multiply_divide #(.WORD_BITS(WB)) uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));

   logic        carry_on_divide;
   mdu_rsp_type pending_results[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          send_gap_pct = 0;
   int          recv_gap_pct = 0;
   int          hold_off = 0;
   int          test_phase = 0;
   logic        hold_started = 0;

   function automatic mdu_rsp_type predict_word_op(mdu_req_type r, logic dsc);
      mdu_rsp_type o;
      longint p;
      logic [31:0] dvd, q, rm, ud;
      logic [15:0] us;
      logic nd, ns, nq, ok;
      o = '0;
      case (r.op)
         OP_MUL: begin
            p = longint'(r.ax) * longint'(r.src);
            o.lo = p[15:0];
            o.hi = p[31:16];
            o.cw = 1; o.ow = 1;
            o.cv = (o.hi != 0); o.ov = o.cv;
         end
         OP_IMUL, OP_IMULT: begin
            p = longint'($signed(r.op == OP_IMUL ? r.ax : r.oth)) * longint'($signed(r.src));
            o.lo = p[15:0];
            o.hi = (r.op == OP_IMUL) ? p[31:16] : 16'd0;
            o.cw = 1; o.ow = 1;
            o.cv = (p < -32768 || p > 32767); o.ov = o.cv;
         end
         OP_DIV, OP_IDIV: begin
            dvd = {r.dx, r.ax};
            ok = (r.src != 0);
            q = 0; rm = 0;
            if (ok && r.op == OP_DIV) begin
               q = dvd / r.src;
               rm = dvd % r.src;
               ok = (q <= 32'hFFFF);
            end else if (ok) begin
               nd = r.dx[15];
               ns = r.src[15];
               ud = nd ? -dvd : dvd;
               us = ns ? -r.src : r.src;
               q = ud / us;
               rm = ud % us;
               nq = nd ^ ns;
               ok = nq ? (q <= 32'h8000) : (q <= 32'h7FFF);
               if (nq) q = -q;
               if (nd) rm = -rm;
            end
            if (ok) begin
               o.lo = q[15:0];
               o.hi = rm[15:0];
               o.cw = dsc; o.cv = dsc;
            end else begin
               o.de = 1;
            end
         end
         default: o = '0;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, mdu_rsp_type got, mdu_rsp_type want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      mdu_rsp_type g, e;
      if (!reset && rsp.valid && rsp.ready) begin
         g = '{rsp.result_low, rsp.result_high, rsp.carry_write, rsp.carry_value,
               rsp.overflow_write, rsp.overflow_value, rsp.divide_error};
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transfer", g, '0);
         end else begin
            e = pending_results.pop_front();
            if (g != e) report_mismatch("response", g, e);
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else if (test_phase == 2 && !hold_started) begin
         hold_started <= 1;
         hold_off <= 200;
         rsp.ready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= 0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_item(mdu_req_type r, logic known, mdu_rsp_type want);
      mdu_rsp_type pred;
      while ($urandom_range(99) < send_gap_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      {req.req_type, req.acc_low, req.acc_high, req.src_operand, req.other_operand} <= r;
      pred = predict_word_op(r, carry_on_divide);
      if (known && pred != want) report_mismatch("table entry", want, pred);
      do @(posedge clock); while (!req.ready);
      pending_results.push_back(known ? want : pred);
   endtask

   task automatic write_div_carry(logic v);
      req.valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      csr.valid <= 1;
      csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 0;
      carry_on_divide = v;
   endtask

   function automatic logic [15:0] rand_word();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         4: return 16'($urandom_range(1, 8));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic mdu_req_type rand_item();
      mdu_req_type r;
      r.op = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
      r.ax = rand_word();
      r.dx = rand_word();
      r.src = rand_word();
      r.oth = rand_word();
      // keep most divides in range so quotients are exercised
      if ((r.op == OP_DIV || r.op == OP_IDIV) && $urandom_range(3) != 0) begin
         if (r.src == 0) r.src = 16'($urandom_range(1, 65535));
         if (r.op == OP_DIV) r.dx = 16'($urandom_range(0, r.src - 1));
         else r.dx = {16{r.ax[15]}};
      end
      return r;
   endfunction

   table_row_type directed[] = '{
      '{'{OP_MUL, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0}, 1,
        '{16'h0001, 16'hFFFE, 1, 1, 1, 1, 0}},
      '{'{OP_MUL, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1,
        '{16'h0, 16'h0, 1, 0, 1, 0, 0}},
      '{'{OP_IMUL, 16'h8000, 16'h0, 16'h8000, 16'h0}, 1,
        '{16'h0000, 16'h4000, 1, 1, 1, 1, 0}},
      '{'{OP_IMUL, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0}, 1,
        '{16'h0001, 16'h0000, 1, 0, 1, 0, 0}},
      '{'{OP_IMULT, 16'h0, 16'h0, 16'hFFFF, 16'h8000}, 1,
        '{16'h8000, 16'h0, 1, 1, 1, 1, 0}},
      '{'{OP_IMULT, 16'h0, 16'h0, 16'h0001, 16'h8000}, 1,
        '{16'h8000, 16'h0, 1, 0, 1, 0, 0}},
      '{'{OP_IMULT, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF}, 0, '0},
      '{'{OP_DIV, 16'h1234, 16'h0, 16'h0000, 16'h0}, 1, '{16'h0, 16'h0, 0, 0, 0, 0, 1}},
      '{'{OP_DIV, 16'h0000, 16'h0001, 16'h0001, 16'h0}, 1,
        '{16'h0, 16'h0, 0, 0, 0, 0, 1}},
      '{'{OP_DIV, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'h0}, 1,
        '{16'hFFFF, 16'hFFFE, 0, 0, 0, 0, 0}},
      '{'{OP_IDIV, 16'h0000, 16'hFFFF, 16'h0002, 16'h0}, 1,
        '{16'h8000, 16'h0, 0, 0, 0, 0, 0}},
      '{'{OP_IDIV, 16'h8000, 16'h0000, 16'h0001, 16'h0}, 1,
        '{16'h0, 16'h0, 0, 0, 0, 0, 1}},
      '{'{OP_IDIV, 16'hFFF9, 16'hFFFF, 16'h0002, 16'h0}, 0, '0},
      '{'{OP_IDIV, 16'h0007, 16'h0000, 16'hFFFE, 16'h0}, 0, '0},
      '{'{OP_IDIV, 16'h0000, 16'h8000, 16'hFFFF, 16'h0}, 1,
        '{16'h0, 16'h0, 0, 0, 0, 0, 1}},
      '{'{OP_IDIV, 16'h1234, 16'h0, 16'h0000, 16'h0}, 1, '{16'h0, 16'h0, 0, 0, 0, 0, 1}},
      '{'{3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, '0},
      '{'{3'd7, 16'h1, 16'h1, 16'h1, 16'h1}, 1, '0}
   };

   initial begin
      mdu_req_type r;
      carry_on_divide = 0;
      req.valid = 0;
      {req.req_type, req.acc_low, req.acc_high, req.src_operand, req.other_operand} = '0;
      csr.valid = 0;
      csr.data = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_item(directed[i].req, directed[i].known, directed[i].rsp);
      write_div_carry(1);
      foreach (directed[i]) send_item(directed[i].req, 0, '0);
      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 7 : (phase == 1) ? 60 : 0;
         recv_gap_pct = (phase == 0) ? 60 : (phase == 1) ? 7 : 0;
         test_phase = phase;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            send_item(rand_item(), 0, '0);
         end
         write_div_carry(phase[0]);
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

// ===== x86_word_multiply_divide.f =====
+incdir+rtl
rtl/xwmd_pkg.sv
rtl/xwmd_if.sv
rtl/xwmd_div_stage.sv
rtl/x86_word_multiply_divide.sv
tb/sv/x86_word_multiply_divide_test.sv
